FILE: rtl/smc_pkg.sv
// shared types, constants and field helpers for the signature match-or-create block
package smc_pkg;

    localparam int FRAC_BITS     = 12;
    localparam int ONE_Q         = 1 << FRAC_BITS;
    localparam int HALF_Q        = 1 << (FRAC_BITS - 1);
    localparam int STORE_ENTRIES = 32;

    localparam int THR_W   = 16;
    localparam int ALPHA_W = 13;
    localparam int SCORE_W = FRAC_BITS + 1;
    localparam int ID_W    = 32;
    localparam int HIT_W   = 32;
    localparam int OP_W    = 22;
    localparam int PROD_W  = 2 * OP_W;
    localparam int SQ_W    = 41;
    localparam int ACC_W   = 48;
    localparam int ROOT_W  = THR_W;
    localparam int USED_W  = 6;

    // distance scale: all weights are over this common denominator
    localparam int T_SCALE = 1600;
    localparam int W_CAD   = 100;
    localparam int W_PEAK  = 4;
    localparam int W_CREST = 25;
    localparam int W_BAND  = 1600;
    localparam int W_ANGLE = 400;

    // configuration register indexes
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_THR   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA = 2'd1;

    localparam int NFIELD = 8;
    localparam logic [2:0] F_CAD   = 3'd0;
    localparam logic [2:0] F_PEAK  = 3'd1;
    localparam logic [2:0] F_CREST = 3'd2;
    localparam logic [2:0] F_LOW   = 3'd3;
    localparam logic [2:0] F_MID   = 3'd4;
    localparam logic [2:0] F_HIGH  = 3'd5;
    localparam logic [2:0] F_AZ    = 3'd6;
    localparam logic [2:0] F_EL    = 3'd7;

    typedef struct packed {
        logic [3:0]         entity_class;
        logic [19:0]        cadence_rate;
        logic signed [19:0] peak_level;
        logic [12:0]        low_band_ratio;
        logic [12:0]        mid_band_ratio;
        logic [12:0]        high_band_ratio;
        logic [19:0]        crest_factor;
        logic [11:0]        azimuth_turns;
        logic [11:0]        elevation_norm;
    } t_in;

    typedef struct packed {
        logic [31:0] entity_id;
        logic        matched;
        logic [12:0] match_score;
        logic        dirty_mark;
        logic [5:0]  entries_used;
    } t_out;

    typedef struct packed {
        logic [ID_W-1:0]    ident;
        logic [3:0]         kind;
        logic [HIT_W-1:0]   hits;
        logic [19:0]        cadence_rate;
        logic signed [19:0] peak_level;
        logic [19:0]        crest_factor;
        logic [12:0]        low_band_ratio;
        logic [12:0]        mid_band_ratio;
        logic [12:0]        high_band_ratio;
        logic [11:0]        azimuth_turns;
        logic [11:0]        elevation_norm;
    } t_entry;

    typedef struct packed {
        logic              done;
        logic [ROOT_W-1:0] root;
        logic [ACC_W-1:0]  scaled;
    } t_root_res;

    // input field k, extended to operand width (sign extended for the peak only)
    function automatic logic signed [OP_W-1:0] f_in_field(t_in x, logic [2:0] k);
        logic signed [OP_W-1:0] v;
        case (k)
            F_CAD:   v = $signed({2'b0, x.cadence_rate});
            F_PEAK:  v = $signed({{2{x.peak_level[19]}}, x.peak_level});
            F_CREST: v = $signed({2'b0, x.crest_factor});
            F_LOW:   v = $signed({9'b0, x.low_band_ratio});
            F_MID:   v = $signed({9'b0, x.mid_band_ratio});
            F_HIGH:  v = $signed({9'b0, x.high_band_ratio});
            F_AZ:    v = $signed({10'b0, x.azimuth_turns});
            default: v = $signed({10'b0, x.elevation_norm});
        endcase
        return v;
    endfunction

    // stored field k, extended to operand width (sign extended for the peak only)
    function automatic logic signed [OP_W-1:0] f_ent_field(t_entry e, logic [2:0] k);
        logic signed [OP_W-1:0] v;
        case (k)
            F_CAD:   v = $signed({2'b0, e.cadence_rate});
            F_PEAK:  v = $signed({{2{e.peak_level[19]}}, e.peak_level});
            F_CREST: v = $signed({2'b0, e.crest_factor});
            F_LOW:   v = $signed({9'b0, e.low_band_ratio});
            F_MID:   v = $signed({9'b0, e.mid_band_ratio});
            F_HIGH:  v = $signed({9'b0, e.high_band_ratio});
            F_AZ:    v = $signed({10'b0, e.azimuth_turns});
            default: v = $signed({10'b0, e.elevation_norm});
        endcase
        return v;
    endfunction

    // write field k of an entry, truncated to its width
    function automatic t_entry f_set_field(t_entry e, logic [2:0] k,
                                           logic signed [OP_W-1:0] v);
        t_entry r;
        r = e;
        case (k)
            F_CAD:   r.cadence_rate    = v[19:0];
            F_PEAK:  r.peak_level      = v[19:0];
            F_CREST: r.crest_factor    = v[19:0];
            F_LOW:   r.low_band_ratio  = v[12:0];
            F_MID:   r.mid_band_ratio  = v[12:0];
            F_HIGH:  r.high_band_ratio = v[12:0];
            F_AZ:    r.azimuth_turns   = v[11:0];
            default: r.elevation_norm  = v[11:0];
        endcase
        return r;
    endfunction

    // azimuth difference folded into half a turn either way
    function automatic logic signed [OP_W-1:0] f_wrap(logic signed [OP_W-1:0] d);
        logic signed [OP_W-1:0] r;
        r = d;
        if (d > $signed(OP_W'(HALF_Q))) begin
            r = d - $signed(OP_W'(ONE_Q));
        end else if (d < -$signed(OP_W'(HALF_Q))) begin
            r = d + $signed(OP_W'(ONE_Q));
        end
        return r;
    endfunction

    // square of field k times its constant weight
    function automatic logic [ACC_W-1:0] f_weigh(logic [SQ_W-1:0] s, logic [2:0] k);
        logic [ACC_W-1:0] w;
        logic [ACC_W-1:0] x;
        x = ACC_W'(s);
        case (k)
            F_CAD:   w = x * ACC_W'(W_CAD);
            F_PEAK:  w = x * ACC_W'(W_PEAK);
            F_CREST: w = x * ACC_W'(W_CREST);
            F_LOW:   w = x * ACC_W'(W_BAND);
            F_MID:   w = x * ACC_W'(W_BAND);
            F_HIGH:  w = x * ACC_W'(W_BAND);
            F_AZ:    w = x * ACC_W'(W_ANGLE);
            default: w = x * ACC_W'(W_ANGLE);
        endcase
        return w;
    endfunction

endpackage

FILE: rtl/smc_isqrt.sv
// bit-serial root: largest d with T_SCALE * d^2 <= value, one root bit per cycle
module smc_isqrt (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [smc_pkg::ACC_W-1:0]    i_value,
    output smc_pkg::t_root_res           o_res
);
    localparam int BW = $clog2(smc_pkg::ROOT_W);
    localparam int EW = smc_pkg::ACC_W + 1;

    logic          r_busy;
    logic          r_done;
    logic [BW-1:0] r_bit;
    logic [smc_pkg::ACC_W-1:0]  r_val;
    logic [EW-1:0]              r_p;
    logic [EW-1:0]              r_q;
    logic [smc_pkg::ROOT_W-1:0] r_d;
    logic [EW-1:0]              w_trial;

    // (d + 2^b)^2 scaled = p + 2^(b+1) * q + scale * 4^b
    assign w_trial = r_p + (r_q << ({1'b0, r_bit} + 1'b1))
                   + (EW'(smc_pkg::T_SCALE) << {r_bit, 1'b0});

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_bit == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val <= i_value;
            r_p   <= '0;
            r_q   <= '0;
            r_d   <= '0;
            r_bit <= BW'(smc_pkg::ROOT_W - 1);
        end else if (r_busy) begin
            if (w_trial <= EW'(r_val)) begin
                r_p        <= w_trial;
                r_q        <= r_q + (EW'(smc_pkg::T_SCALE) << r_bit);
                r_d[r_bit] <= 1'b1;
            end
            r_bit <= r_bit - 1'b1;
        end
    end

    assign o_res.done   = r_done;
    assign o_res.root   = r_d;
    assign o_res.scaled = r_p[smc_pkg::ACC_W-1:0];

endmodule

FILE: rtl/smc_div.sv
// restoring divider for the match score: floor(num * ONE / den), num <= den
module smc_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [smc_pkg::THR_W-1:0]     i_num,
    input  logic [smc_pkg::THR_W-1:0]     i_den,
    output logic                          o_done,
    output logic [smc_pkg::SCORE_W-1:0]   o_quo
);
    localparam int CW = $clog2(smc_pkg::SCORE_W);
    localparam int RW = smc_pkg::THR_W + 1;

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [RW-1:0] r_rem;
    logic [smc_pkg::THR_W-1:0]   r_den;
    logic [smc_pkg::SCORE_W-1:0] r_quo;
    logic          w_ge;
    logic [RW-1:0] w_rem;

    assign w_ge  = r_rem >= {1'b0, r_den};
    assign w_rem = w_ge ? r_rem - {1'b0, r_den} : r_rem;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // one quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {1'b0, i_num};
            r_den <= i_den;
            r_quo <= '0;
            r_cnt <= CW'(smc_pkg::SCORE_W - 1);
        end else if (r_busy) begin
            r_rem <= {w_rem[RW-2:0], 1'b0};
            r_quo <= {r_quo[smc_pkg::SCORE_W-2:0], w_ge};
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

FILE: rtl/signature_match_or_create.sv
// signature store top level: entry scan sequencer, shared multiplier and entry memory
//
// Usage: an input transaction carries a class code and an eight-field
// signature; one result transaction comes back for each input, in order.
// The block scans every table entry through the entry memory, one entry at
// a time; used entries of the same class get a weighted squared distance
// from the shared multiplier, and a nearer one gets its root from the
// bit-serial root unit. The nearest entry below the match threshold is
// blended toward the input on the same multiplier and scored by the serial
// divider; otherwise an entry is created. One item at a time: o_in_stall
// is high from acceptance until the result is written to the output
// register. A waiting result does not block the next input; a stalled
// output only holds the sequencer at its final step. The user writes
// configuration through the write port only while the block is idle; the
// block itself does not enforce this. Reset (synchronous, active low)
// empties the table, restarts ids at one and restores the default
// threshold and blend weight; no clearing pass.
module signature_match_or_create #(
    parameter int STORE_ENTRIES = smc_pkg::STORE_ENTRIES
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  smc_pkg::t_in                       i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output smc_pkg::t_out                      o_out_data,
    input  logic                               i_cfg_we,
    input  logic [smc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [smc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    localparam int IW = (STORE_ENTRIES > 1) ? $clog2(STORE_ENTRIES) : 1;
    localparam int CW = $clog2(STORE_ENTRIES + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(STORE_ENTRIES - 1);

    typedef enum logic [13:0] {
        S_IDLE  = 14'b00000000000001,
        S_THR   = 14'b00000000000010,
        S_BND   = 14'b00000000000100,
        S_RD    = 14'b00000000001000,
        S_CHK   = 14'b00000000010000,
        S_SQ    = 14'b00000000100000,
        S_CMP   = 14'b00000001000000,
        S_ROOT  = 14'b00000010000000,
        S_NEXT  = 14'b00000100000000,
        S_DEC   = 14'b00001000000000,
        S_BRD   = 14'b00010000000000,
        S_BLEND = 14'b00100000000000,
        S_SCORE = 14'b01000000000000,
        S_WR    = 14'b10000000000000
    } t_state;

    t_state r_state;

    logic [smc_pkg::THR_W-1:0]   r_thr;
    logic [smc_pkg::ALPHA_W-1:0] r_alpha;
    logic [STORE_ENTRIES-1:0]    r_used_bits;
    logic [CW-1:0]               r_used;
    logic [smc_pkg::ID_W-1:0]    r_next_id;

    smc_pkg::t_in    r_in;
    smc_pkg::t_entry r_mem [STORE_ENTRIES];
    smc_pkg::t_entry r_rd;
    smc_pkg::t_entry r_work;
    smc_pkg::t_entry w_wr_rec;

    logic [IW-1:0]              r_idx;
    logic [IW-1:0]              r_slot;
    logic [IW-1:0]              r_best_i;
    logic [IW-1:0]              r_few_i;
    logic [smc_pkg::HIT_W-1:0]  r_few;
    logic                       r_best_found;
    logic [smc_pkg::ROOT_W-1:0] r_best_d;
    logic [smc_pkg::ACC_W-1:0]  r_bt;
    logic [smc_pkg::ACC_W-1:0]  r_acc;
    logic [3:0]                 r_k;

    logic signed [smc_pkg::OP_W-1:0]   w_mul_a;
    logic signed [smc_pkg::OP_W-1:0]   w_mul_b;
    logic signed [smc_pkg::PROD_W-1:0] r_prod;
    logic signed [smc_pkg::OP_W-1:0]   w_diff;
    logic signed [smc_pkg::PROD_W-1:0] w_rnd;
    logic signed [smc_pkg::PROD_W-1:0] w_sh;
    logic signed [smc_pkg::OP_W-1:0]   w_blend_v;
    logic [2:0]                        w_kp;
    logic [smc_pkg::ALPHA_W-1:0]       w_alpha;

    logic          w_free_found;
    logic [IW-1:0] w_free_i;
    logic          w_root_start;
    logic          w_div_start;
    logic          w_div_done;
    logic [smc_pkg::SCORE_W-1:0] w_quo;
    smc_pkg::t_root_res          w_root;
    logic          w_hit_sat;
    logic [smc_pkg::HIT_W-1:0]   w_hits_new;
    logic          w_out_free;
    logic          w_out_fire;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_out_fire = o_out_valid && !i_out_stall;
    assign w_out_free = !(o_out_valid && i_out_stall);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr   <= smc_pkg::THR_W'(2253);
            r_alpha <= smc_pkg::ALPHA_W'(1434);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                smc_pkg::CFG_THR:   r_thr   <= i_cfg_data;
                smc_pkg::CFG_ALPHA: r_alpha <= i_cfg_data[smc_pkg::ALPHA_W-1:0];
                default: ;
            endcase
        end
    end

    // blend weight limited to one
    assign w_alpha = (r_alpha > smc_pkg::ALPHA_W'(smc_pkg::ONE_Q))
                   ? smc_pkg::ALPHA_W'(smc_pkg::ONE_Q) : r_alpha;

    // field difference for the current step
    assign w_kp = r_k[2:0] - 3'd1;
    always_comb begin
        w_diff = smc_pkg::f_in_field(r_in, r_k[2:0])
               - smc_pkg::f_ent_field(r_rd, r_k[2:0]);
        if (r_state == S_SQ && r_k[2:0] == smc_pkg::F_AZ) begin
            w_diff = smc_pkg::f_wrap(w_diff);
        end
    end

    // shared multiplier operand select
    always_comb begin
        case (r_state)
            S_THR: begin
                w_mul_a = $signed({6'b0, r_thr});
                w_mul_b = $signed({6'b0, r_thr});
            end
            S_BLEND: begin
                w_mul_a = $signed({9'b0, w_alpha});
                w_mul_b = w_diff;
            end
            default: begin
                w_mul_a = w_diff;
                w_mul_b = w_diff;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_mul_a * w_mul_b;
    end

    // rounded blend of the previous step's field
    assign w_rnd     = r_prod + $signed(smc_pkg::PROD_W'(smc_pkg::HALF_Q));
    assign w_sh      = w_rnd >>> smc_pkg::FRAC_BITS;
    assign w_blend_v = smc_pkg::f_ent_field(r_rd, w_kp) + w_sh[smc_pkg::OP_W-1:0];

    // first free entry
    always_comb begin
        w_free_found = 1'b0;
        w_free_i     = '0;
        for (int j = STORE_ENTRIES - 1; j >= 0; j--) begin
            if (!r_used_bits[j]) begin
                w_free_found = 1'b1;
                w_free_i     = IW'(j);
            end
        end
    end

    // entry memory, registered read
    always_ff @(posedge i_clk) begin
        if (r_state == S_WR && w_out_free) begin
            r_mem[r_slot] <= w_wr_rec;
        end
        r_rd <= r_mem[r_idx];
    end

    // hit count update on a match
    assign w_hit_sat  = (r_work.hits == '1);
    assign w_hits_new = w_hit_sat ? r_work.hits : r_work.hits + 1'b1;
    always_comb begin
        w_wr_rec = r_work;
        if (r_best_found) begin
            w_wr_rec.hits = w_hits_new;
        end
    end

    assign w_root_start = (r_state == S_CMP) && (r_acc < r_bt);
    assign w_div_start  = (r_state == S_BLEND) && (r_k == 4'd8);

    smc_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_root_start),
        .i_value (r_acc),
        .o_res   (w_root)
    );

    smc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_thr - r_best_d),
        .i_den   (r_thr),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    // sequencer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used_bits <= '0;
            r_used      <= '0;
            r_next_id   <= smc_pkg::ID_W'(1);
            o_out_valid <= 1'b0;
        end else begin
            if (w_out_fire && r_state != S_WR) begin
                o_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_THR;
                    end
                end
                S_THR:  r_state <= S_BND;
                S_BND:  r_state <= S_RD;
                S_RD:   r_state <= S_CHK;
                S_CHK: begin
                    if (r_used_bits[r_idx] && r_rd.kind == r_in.entity_class) begin
                        r_state <= S_SQ;
                    end else begin
                        r_state <= S_NEXT;
                    end
                end
                S_SQ: begin
                    if (r_k == 4'd8) begin
                        r_state <= S_CMP;
                    end
                end
                S_CMP:  r_state <= w_root_start ? S_ROOT : S_NEXT;
                S_ROOT: begin
                    if (w_root.done) begin
                        r_state <= S_NEXT;
                    end
                end
                S_NEXT: r_state <= (r_idx == LAST_IDX) ? S_DEC : S_RD;
                S_DEC:  r_state <= r_best_found ? S_BRD : S_WR;
                S_BRD:  r_state <= S_BLEND;
                S_BLEND: begin
                    if (r_k == 4'd8) begin
                        r_state <= S_SCORE;
                    end
                end
                S_SCORE: begin
                    if (w_div_done) begin
                        r_state <= S_WR;
                    end
                end
                S_WR: begin
                    if (w_out_free) begin
                        r_state     <= S_IDLE;
                        o_out_valid <= 1'b1;
                        r_used_bits[r_slot] <= 1'b1;
                        if (!r_used_bits[r_slot]) begin
                            r_used <= r_used + 1'b1;
                        end
                        if (!r_best_found) begin
                            r_next_id <= (r_next_id == '1) ? smc_pkg::ID_W'(1)
                                                           : r_next_id + 1'b1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // sequencer datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    r_in <= i_in_data;
                end
            end
            S_BND: begin
                r_bt         <= smc_pkg::ACC_W'(r_prod[31:0]) * smc_pkg::ACC_W'(smc_pkg::T_SCALE);
                r_idx        <= '0;
                r_best_found <= 1'b0;
                r_best_i     <= '0;
                r_best_d     <= r_thr;
                r_few        <= '1;
                r_few_i      <= '0;
            end
            S_CHK: begin
                r_k   <= '0;
                r_acc <= '0;
                if (r_used_bits[r_idx] && r_rd.hits <= r_few) begin
                    r_few   <= r_rd.hits;
                    r_few_i <= r_idx;
                end
            end
            S_SQ: begin
                r_k <= r_k + 1'b1;
                if (r_k != '0) begin
                    r_acc <= r_acc + smc_pkg::f_weigh(r_prod[smc_pkg::SQ_W-1:0], w_kp);
                end
            end
            S_ROOT: begin
                if (w_root.done) begin
                    r_best_found <= 1'b1;
                    r_best_i     <= r_idx;
                    r_best_d     <= w_root.root;
                    r_bt         <= w_root.scaled;
                end
            end
            S_NEXT: begin
                if (r_idx != LAST_IDX) begin
                    r_idx <= r_idx + 1'b1;
                end
            end
            S_DEC: begin
                r_k <= '0;
                if (r_best_found) begin
                    r_idx  <= r_best_i;
                    r_slot <= r_best_i;
                end else begin
                    r_slot <= w_free_found ? w_free_i : r_few_i;
                    r_work.ident           <= r_next_id;
                    r_work.kind            <= r_in.entity_class;
                    r_work.hits            <= smc_pkg::HIT_W'(1);
                    r_work.cadence_rate    <= r_in.cadence_rate;
                    r_work.peak_level      <= r_in.peak_level;
                    r_work.crest_factor    <= r_in.crest_factor;
                    r_work.low_band_ratio  <= r_in.low_band_ratio;
                    r_work.mid_band_ratio  <= r_in.mid_band_ratio;
                    r_work.high_band_ratio <= r_in.high_band_ratio;
                    r_work.azimuth_turns   <= r_in.azimuth_turns;
                    r_work.elevation_norm  <= r_in.elevation_norm;
                end
            end
            S_BLEND: begin
                r_k <= r_k + 1'b1;
                if (r_k == '0) begin
                    r_work <= r_rd;
                end else begin
                    r_work <= smc_pkg::f_set_field(r_work, w_kp, w_blend_v);
                end
            end
            S_WR: begin
                if (w_out_free) begin
                    o_out_data.entity_id    <= r_work.ident;
                    o_out_data.matched      <= r_best_found;
                    o_out_data.match_score  <= r_best_found ? w_quo : '0;
                    o_out_data.dirty_mark   <= r_best_found
                        ? (!w_hit_sat && w_hits_new[2:0] == 3'd0) : 1'b1;
                    o_out_data.entries_used <= smc_pkg::USED_W'(r_used)
                        + smc_pkg::USED_W'(!r_used_bits[r_slot]);
                end
            end
            default: ;
        endcase
    end

    // checks
    a_used_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used == CW'($countones(r_used_bits)))
        else $error("used count out of step with used bits");

    a_best_below_thr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE && r_state != S_THR && r_state != S_BND && r_best_found)
        |-> r_best_d < r_thr)
        else $error("nearest distance not below threshold");

    a_root_in_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_root.done |-> r_state == S_ROOT)
        else $error("root result outside root wait");

    a_create_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_fire && !o_out_data.matched)
        |-> (o_out_data.match_score == '0 && o_out_data.dirty_mark))
        else $error("create result has score or lacks dirty mark");

    a_result_issued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WR && w_out_free) |=> (o_out_valid && r_state == S_IDLE))
        else $error("final step did not load the output register");

endmodule

FILE: tb/signature_match_or_create_tb.sv
// testbench for the signature match-or-create block: predictor, scoreboard and drivers
module signature_match_or_create_tb;
    import smc_pkg::*;

    localparam int CYCLE_LIMIT = 20_000_000;
    localparam int RAND_PER_PHASE = 350;
    localparam int NPHASE = 5;

    // predictor of the entry table and queue of expected reports
    class sig_store_scoreboard;
        logic [15:0] thr;
        logic [12:0] alpha;
        bit          used[STORE_ENTRIES];
        logic [31:0] ident[STORE_ENTRIES];
        logic [3:0]  kind[STORE_ENTRIES];
        logic [31:0] hits[STORE_ENTRIES];
        longint      sig[STORE_ENTRIES][NFIELD];
        logic [31:0] next_id;
        t_out        pending[$];
        int          errors;

        function void clear();
            thr = 16'd2253;
            alpha = 13'd1434;
            next_id = 32'd1;
            errors = 0;
            foreach (used[i]) used[i] = 0;
            pending.delete();
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
            if (idx == CFG_THR) thr = v;
            else if (idx == CFG_ALPHA) alpha = v[12:0];
        endfunction

        function longint unsigned int_root(longint unsigned v);
            longint unsigned r;
            longint unsigned b;
            r = 0;
            b = 64'd1 << 62;
            while (b > v) b >>= 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v -= r + b;
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        function longint unsigned sqr(longint d);
            longint unsigned m;
            m = (d < 0) ? -d : d;
            return m * m;
        endfunction

        // fields in table order: cadence, peak, crest, low, mid, high, az, el
        function void unpack_sig(t_in x, output longint f[NFIELD]);
            f[F_CAD]   = x.cadence_rate;
            f[F_PEAK]  = longint'(signed'(x.peak_level));
            f[F_CREST] = x.crest_factor;
            f[F_LOW]   = x.low_band_ratio;
            f[F_MID]   = x.mid_band_ratio;
            f[F_HIGH]  = x.high_band_ratio;
            f[F_AZ]    = x.azimuth_turns;
            f[F_EL]    = x.elevation_norm;
        endfunction

        function longint unsigned entry_dist(int i, longint f[NFIELD]);
            longint daz;
            longint unsigned t;
            daz = sig[i][F_AZ] - f[F_AZ];
            if (daz > ONE_Q / 2) daz -= ONE_Q;
            if (daz < -(ONE_Q / 2)) daz += ONE_Q;
            t = 100 * sqr(sig[i][F_CAD] - f[F_CAD]) + 4 * sqr(sig[i][F_PEAK] - f[F_PEAK])
              + 1600 * (sqr(sig[i][F_LOW] - f[F_LOW]) + sqr(sig[i][F_MID] - f[F_MID])
                      + sqr(sig[i][F_HIGH] - f[F_HIGH]))
              + 25 * sqr(sig[i][F_CREST] - f[F_CREST])
              + 400 * sqr(daz) + 400 * sqr(sig[i][F_EL] - f[F_EL]);
            return int_root(t / 1600);
        endfunction

        // accepted input transaction: update table and queue the report
        function void note_detection(t_in x);
            longint f[NFIELD];
            longint unsigned best_d;
            longint unsigned d;
            longint a;
            int best;
            int slot;
            int fewest_i;
            logic [31:0] fewest;
            t_out r;
            int cnt;
            unpack_sig(x, f);
            best_d = thr;
            best = -1;
            r = '0;
            for (int i = 0; i < STORE_ENTRIES; i++) begin
                if (!used[i] || kind[i] != x.entity_class) continue;
                d = entry_dist(i, f);
                if (d < best_d) begin
                    best_d = d;
                    best = i;
                end
            end
            if (best >= 0) begin
                a = (alpha > ONE_Q) ? ONE_Q : alpha;
                // arithmetic shift gives floor division for the signed peak
                for (int k = 0; k < NFIELD; k++)
                    sig[best][k] = ((ONE_Q - a) * sig[best][k] + a * f[k] + ONE_Q / 2) >>> 12;
                if (hits[best] != 32'hFFFF_FFFF) begin
                    hits[best]++;
                    if (hits[best][2:0] == 3'd0) r.dirty_mark = 1'b1;
                end
                r.entity_id = ident[best];
                r.matched = 1'b1;
                r.match_score = 13'(((longint'(thr) - best_d) << FRAC_BITS) / thr);
            end else begin
                slot = -1;
                fewest_i = 0;
                fewest = 32'hFFFF_FFFF;
                for (int i = 0; i < STORE_ENTRIES; i++) begin
                    if (!used[i]) begin
                        slot = i;
                        break;
                    end
                    if (hits[i] <= fewest) begin
                        fewest = hits[i];
                        fewest_i = i;
                    end
                end
                if (slot < 0) slot = fewest_i;
                r.entity_id = next_id;
                next_id++;
                if (next_id == 0) next_id = 1;
                used[slot] = 1;
                ident[slot] = r.entity_id;
                kind[slot] = x.entity_class;
                hits[slot] = 1;
                for (int k = 0; k < NFIELD; k++) sig[slot][k] = f[k];
                r.dirty_mark = 1'b1;
            end
            cnt = 0;
            foreach (used[i]) if (used[i]) cnt++;
            r.entries_used = 6'(cnt);
            pending.push_back(r);
        endfunction

        // accepted output transaction against the oldest expectation
        function void check_report(t_out got);
            t_out e;
            if (pending.size() == 0) begin
                $error("unexpected result transaction id=%0d", got.entity_id);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.entity_id !== e.entity_id) begin
                $error("entity_id: expected %0d actual %0d", e.entity_id, got.entity_id);
                errors++;
            end
            if (got.matched !== e.matched) begin
                $error("matched: expected %0d actual %0d", e.matched, got.matched);
                errors++;
            end
            if (got.match_score !== e.match_score) begin
                $error("match_score: expected %0d actual %0d", e.match_score, got.match_score);
                errors++;
            end
            if (got.dirty_mark !== e.dirty_mark) begin
                $error("dirty_mark: expected %0d actual %0d", e.dirty_mark, got.dirty_mark);
                errors++;
            end
            if (got.entries_used !== e.entries_used) begin
                $error("entries_used: expected %0d actual %0d", e.entries_used, got.entries_used);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    t_in                   i_in_data;
    logic                  o_out_valid;
    logic                  i_out_stall;
    t_out                  o_out_data;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    sig_store_scoreboard sb;
    int idle_pct;
    int stall_pct;
    longint cycles;
    t_in recent[$];

    signature_match_or_create dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("** signature_match_or_create: FAILED **");
                $finish;
            end
        end
    end

    // result side: check accepted transactions and stall at random
    initial begin
        wait (sb != null);
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) sb.check_report(o_out_data);
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // send one detection, idling first at random
    task automatic send_detection(t_in x);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= x;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_detection(x);
        recent.push_back(x);
        if (recent.size() > 40) void'(recent.pop_front());
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        sb.set_reg(idx, v);
    endtask

    // wait until every queued report has come back
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic t_in random_detection();
        t_in x;
        x.entity_class = 4'($urandom_range(15));
        x.cadence_rate = 20'($urandom);
        x.peak_level = 20'($urandom);
        x.low_band_ratio = 13'($urandom);
        x.mid_band_ratio = 13'($urandom);
        x.high_band_ratio = 13'($urandom);
        x.crest_factor = 20'($urandom);
        x.azimuth_turns = 12'($urandom);
        x.elevation_norm = 12'($urandom);
        return x;
    endfunction

    // small move around a recent detection of the same class; fields wrap
    function automatic t_in nearby_detection();
        t_in x;
        x = recent[$urandom_range(recent.size() - 1)];
        x.cadence_rate += 20'($urandom_range(3000) - 1500);
        x.peak_level += 20'($urandom_range(16000) - 8000);
        x.crest_factor += 20'($urandom_range(8000) - 4000);
        x.low_band_ratio += 13'($urandom_range(600) - 300);
        x.mid_band_ratio += 13'($urandom_range(600) - 300);
        x.high_band_ratio += 13'($urandom_range(600) - 300);
        x.azimuth_turns += 12'($urandom_range(1200) - 600);
        x.elevation_norm += 12'($urandom_range(1200) - 600);
        return x;
    endfunction

    task automatic directed_part();
        t_in x;
        t_in y;
        // all zero, then repeated past the eighth hit, which sets the dirty mark
        x = '0;
        repeat (9) send_detection(x);
        // all ones, and the signed peak extremes
        send_detection('1);
        y = '1;
        y.peak_level = 20'sh80000;
        send_detection(y);
        y.peak_level = 20'sh7FFFF;
        send_detection(y);
        // same signature in another class creates
        x = '0;
        x.entity_class = 4'd5;
        send_detection(x);
        // azimuth across the wrap point still matches
        x.azimuth_turns = 12'd4095;
        x.low_band_ratio = 13'd4096;
        send_detection(x);
        x.azimuth_turns = 12'd20;
        send_detection(x);
        // band ratios beyond one
        x.mid_band_ratio = 13'h1FFF;
        x.high_band_ratio = 13'h1FFF;
        send_detection(x);
        send_detection(x);
    endtask

    initial begin
        int thr_set[NPHASE] = '{2253, 0, 65535, 1, 3000};
        int alpha_set[NPHASE] = '{1434, 4096, 0, 8191, 2000};
        int idle_set[NPHASE] = '{0, 88, 0, 12, 30};
        int stall_set[NPHASE] = '{0, 0, 88, 12, 0};
        sb = new();
        sb.clear();
        idle_pct = 0;
        stall_pct = 0;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data <= '0;
        i_out_stall <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= CFG_THR;
        i_cfg_data <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        directed_part();
        for (int p = 0; p < NPHASE; p++) begin
            drain();
            write_reg(CFG_THR, CFG_DATA_W'(thr_set[p]));
            write_reg(CFG_ALPHA, CFG_DATA_W'(alpha_set[p]));
            // indexes past the last register are ignored
            if (p == 1) write_reg(2'd2, 16'hFFFF);
            if (p == 1) write_reg(2'd3, 16'h0000);
            i_cfg_we <= 1'b0;
            idle_pct = idle_set[p];
            stall_pct = stall_set[p];
            for (int n = 0; n < RAND_PER_PHASE; n++) begin
                if ($urandom_range(99) < 70) send_detection(nearby_detection());
                else send_detection(random_detection());
            end
        end
        idle_pct = 0;
        stall_pct = 0;
        drain();
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("** signature_match_or_create: PASSED **");
        end else begin
            $display("** signature_match_or_create: FAILED **");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/smc_pkg.sv
rtl/smc_isqrt.sv
rtl/smc_div.sv
rtl/signature_match_or_create.sv
tb/signature_match_or_create_tb.sv
